// File: design/rilbp_pkg.sv
// Shared types, constants and pattern functions for the rotation-invariant LBP unit.
package rilbp_pkg;

  localparam int WIDTH_MAX  = 1024;
  localparam int ADDR_BITS  = $clog2(WIDTH_MAX);
  localparam int PIX_BITS   = 8;
  localparam int WIN_TAPS   = 9;
  localparam int CODE_BITS  = 8;
  localparam int CFG_BITS   = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int WCFG_BITS  = 11;
  localparam int ROW_BITS   = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [ADDR_BITS-1:0] COL_LAST_RST = ADDR_BITS'(WIDTH_MAX - 1);
  localparam logic [ROW_BITS-1:0]  ROW_LAST_RST = ROW_BITS'(1023);

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [WIN_TAPS-1:0][PIX_BITS-1:0] win_t;

  typedef struct packed {
    logic hit;
    logic row_end;
    logic frame_end;
  } tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
    pix_t up;
    pix_t mid;
    pix_t px;
  } col_t;

  function automatic logic [CODE_BITS-1:0] lbp_bits(input win_t w);
    pix_t ctr;
    ctr = w[4];
    lbp_bits = {w[0] >= ctr, w[1] >= ctr, w[2] >= ctr, w[5] >= ctr,
                w[8] >= ctr, w[7] >= ctr, w[6] >= ctr, w[3] >= ctr};
  endfunction

  function automatic logic [CODE_BITS-1:0] min_rotation(input logic [CODE_BITS-1:0] v);
    logic [CODE_BITS-1:0] best;
    logic [CODE_BITS-1:0] rot;
    best = v;
    rot  = v;
    for (int k = 1; k < CODE_BITS; k++) begin
      rot = {rot[CODE_BITS-2:0], rot[CODE_BITS-1]};
      if (rot < best) best = rot;
    end
    min_rotation = best;
  endfunction

endpackage

// File: design/rilbp_line_buf.sv
// Line stores, raster counters and frame configuration for the LBP unit.
module rilbp_line_buf import rilbp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  pix_t                    in_pixel_value,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_wdata,
  output col_t                    col_out
);

  logic [2*PIX_BITS-1:0] mem [WIDTH_MAX];
  logic [2*PIX_BITS-1:0] rd_r;

  logic [ADDR_BITS-1:0] col_r, col_nxt, col_last_r, col_last_nxt;
  logic [ROW_BITS-1:0]  row_r, row_nxt, row_last_r, row_last_nxt;
  logic [ADDR_BITS-1:0] addr_r;
  logic                 valid_r;
  tag_t                 tag_r;
  pix_t                 px_r;

  logic                 take;
  logic                 last_col, last_row, cfg_hit;
  logic [WCFG_BITS-1:0] w_in, w_m1;
  logic [ROW_BITS-1:0]  h_in;

  assign take     = en && in_valid;
  assign last_col = (col_r == col_last_r);
  assign last_row = (row_r == row_last_r);
  assign w_in     = cfg_wdata[WCFG_BITS-1:0];
  assign w_m1     = w_in - WCFG_BITS'(1);
  assign h_in     = cfg_wdata[ROW_BITS-1:0];

  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    cfg_hit      = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH: begin
          cfg_hit = 1'b1;
          if (w_in == '0) col_last_nxt = '0;
          else if (w_in > WCFG_BITS'(WIDTH_MAX)) col_last_nxt = COL_LAST_RST;
          else col_last_nxt = w_m1[ADDR_BITS-1:0];
        end
        CFG_IDX_HEIGHT: begin
          cfg_hit = 1'b1;
          row_last_nxt = (h_in == '0) ? '0 : h_in - ROW_BITS'(1);
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + ADDR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      col_last_r <= COL_LAST_RST;
      row_last_r <= ROW_LAST_RST;
      valid_r    <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
      if (en) valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_r        <= col_r;
      px_r          <= in_pixel_value;
      tag_r.hit     <= (row_r >= ROW_BITS'(2)) && (col_r >= ADDR_BITS'(2));
      tag_r.row_end <= last_col;
      tag_r.frame_end <= last_col && last_row;
    end
  end

  // Upper half holds the row two above, lower half the row just above.
  always_ff @(posedge clk) begin
    if (take) rd_r <= mem[col_r];
    if (en && valid_r) mem[addr_r] <= {rd_r[PIX_BITS-1:0], px_r};
  end

  assign col_out.valid = valid_r;
  assign col_out.tag   = tag_r;
  assign col_out.up    = rd_r[2*PIX_BITS-1:PIX_BITS];
  assign col_out.mid   = rd_r[PIX_BITS-1:0];
  assign col_out.px    = px_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= col_last_r)
    else $error("column counter beyond last column");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= row_last_r)
    else $error("row counter beyond last row");

endmodule

// File: design/rilbp_window.sv
// 3x3 neighborhood window registers fed one column at a time.
module rilbp_window import rilbp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  col_t col_in,
  output win_t win,
  output tag_t tag,
  output logic hit
);

  win_t win_r;
  tag_t tag_r;
  logic hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (en) begin
      hit_r <= col_in.valid && col_in.tag.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en && col_in.valid) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= col_in.up;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= col_in.mid;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= col_in.px;
      tag_r    <= col_in.tag;
    end
  end

  assign win = win_r;
  assign tag = tag_r;
  assign hit = hit_r;

endmodule

// File: design/rotation_invariant_lbp_3x3_unit.sv
// Top level of the streaming rotation-invariant 3x3 LBP unit.
// Pixels enter on the in_ channel in raster order, one request per pixel.
// For each interior pixel one request leaves on the out_ channel carrying
// the minimum-rotation pattern code plus row-end and frame-end flags.
// Border pixels and images smaller than 3x3 produce no output request.
// The cfg_ port writes image width (index 0) and height (index 1); any such
// write restarts the frame at the top-left pixel.
// Throughput is one pixel per clock while the output is not stalled. An output
// request appears once the pixel that completes its window has passed the line
// store read register, the window shift register and then the code register.
// While the output register is full and the receiver stalls, the whole pipeline
// holds and in_stall rises.
// After reset the frame is 1024 by 1024 and the pipeline is empty; the line
// stores need no clearing because each entry is rewritten before use.
module rotation_invariant_lbp_3x3_unit import rilbp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pix_t                    in_pixel_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CODE_BITS-1:0]    out_pattern_code,
  output logic                    out_row_end,
  output logic                    out_frame_end,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_wdata
);

  logic                 en;
  col_t                 col;
  win_t                 win;
  tag_t                 tag;
  logic                 hit;
  logic                 out_valid_r;
  logic [CODE_BITS-1:0] code_r;
  logic                 row_end_r, frame_end_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  rilbp_line_buf u_line_buf (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .in_pixel_value (in_pixel_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .col_out        (col)
  );

  rilbp_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .col_in (col),
    .win    (win),
    .tag    (tag),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en && hit) begin
      code_r      <= min_rotation(lbp_bits(win));
      row_end_r   <= tag.row_end;
      frame_end_r <= tag.frame_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pattern_code = code_r;
  assign out_row_end      = row_end_r;
  assign out_frame_end    = frame_end_r;

  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output register is free");

endmodule

// File: tb/rotation_invariant_lbp_3x3_unit_tb.sv
// Self-checking testbench for the streaming rotation-invariant 3x3 LBP unit.
`timescale 1ns / 100ps

module rotation_invariant_lbp_3x3_unit_tb;
  import rilbp_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1500;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned REPORT_MAX    = 10;
  localparam longint      TIMEOUT_NS    = 4_000_000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE3 = 2'd3;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 row_end;
    logic                 frame_end;
  } code_rec_t;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} plan_kind_t;

  typedef struct {
    plan_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [CFG_BITS-1:0]       data;
    pix_t                      px;
    bit                        typed;
    bit                        has_res;
    code_rec_t                 rec;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  pix_t                    in_pixel_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CODE_BITS-1:0]    out_pattern_code;
  logic                    out_row_end;
  logic                    out_frame_end;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_wdata = '0;

  rotation_invariant_lbp_3x3_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pattern_code (out_pattern_code),
    .out_row_end      (out_row_end),
    .out_frame_end    (out_frame_end),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  logic [WCFG_BITS-1:0] img_width;
  logic [ROW_BITS-1:0]  img_height;
  pix_t                 older_row [WIDTH_MAX];
  pix_t                 newer_row [WIDTH_MAX];
  pix_t                 win [WIN_TAPS];
  int unsigned          next_col;
  int unsigned          next_row;

  code_rec_t   expected_codes[$];
  plan_row_t   plan[$];
  int unsigned mismatches = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned plain_items = 0;

  function automatic bit step_window(input pix_t px, output code_rec_t rec);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    pix_t ctr;
    logic [CODE_BITS-1:0] bits;
    logic [2*CODE_BITS-1:0] twice;
    bit hit;
    w = (img_width == '0) ? 1 : img_width;
    if (w > WIDTH_MAX) w = WIDTH_MAX;
    h = (img_height == '0) ? 1 : img_height;
    c = (next_col >= w) ? 0 : next_col;
    r = (next_row >= h) ? 0 : next_row;
    win[0] = win[1]; win[1] = win[2];
    win[3] = win[4]; win[4] = win[5];
    win[6] = win[7]; win[7] = win[8];
    win[2] = older_row[c];
    win[5] = newer_row[c];
    win[8] = px;
    older_row[c] = newer_row[c];
    newer_row[c] = px;
    rec = '0;
    hit = (r >= 2) && (c >= 2);
    if (hit) begin
      ctr = win[4];
      bits = {win[0] >= ctr, win[1] >= ctr, win[2] >= ctr, win[5] >= ctr,
              win[8] >= ctr, win[7] >= ctr, win[6] >= ctr, win[3] >= ctr};
      twice = {bits, bits};
      rec.code = bits;
      for (int k = 1; k < CODE_BITS; k++) begin
        if (twice[k +: CODE_BITS] < rec.code) rec.code = twice[k +: CODE_BITS];
      end
      rec.row_end = (c == w - 1);
      rec.frame_end = rec.row_end && (r == h - 1);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = c;
    next_row = r;
    return hit;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_t pick_pixel(input pix_t lvl);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return pix_t'($urandom_range(0, 255));
    if (r < 80) return lvl ^ pix_t'($urandom_range(0, 3));
    return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
  endfunction

  function automatic void add_px(input pix_t px, input bit typed, input bit has_res,
                                 input code_rec_t rec);
    plan_row_t row;
    row = '{kind: ROW_PIXEL, idx: '0, data: '0, px: px, typed: typed,
            has_res: has_res, rec: rec};
    plan.push_back(row);
  endfunction

  function automatic void add_wr(input logic [CFG_IDX_BITS-1:0] idx,
                                 input logic [CFG_BITS-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_WRITE, idx: idx, data: data, px: '0, typed: 1'b0,
            has_res: 1'b0, rec: '0};
    plan.push_back(row);
  endfunction

  task automatic report_miss(input string what, input code_rec_t want, input code_rec_t seen);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%s: expected code %02h row_end %0b frame_end %0b, got code %02h row_end %0b frame_end %0b",
               what, want.code, want.row_end, want.frame_end,
               seen.code, seen.row_end, seen.frame_end);
    end
  endtask

  task automatic offer_pixel(input pix_t px);
    in_valid <= 1'b1;
    in_pixel_value <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_results(input int unsigned tail);
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_codes.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_IDX_WIDTH || idx == CFG_IDX_HEIGHT) begin
      if (idx == CFG_IDX_WIDTH) img_width = val[WCFG_BITS-1:0];
      else img_height = val[ROW_BITS-1:0];
      next_col = 0;
      next_row = 0;
    end
  endtask

  task automatic run_phase(input int unsigned ph);
    logic [CFG_BITS-1:0] wv;
    logic [CFG_BITS-1:0] hv;
    int unsigned n;
    int unsigned frame_px;
    int unsigned pick;
    bit quiet;
    bit pause;
    bit hold;
    bit set_w;
    bit set_h;
    bit junk;
    pix_t lvl;
    pix_t px;
    code_rec_t rec;
    quiet = ($urandom_range(0, 3) == 0);
    pause = ($urandom_range(0, 4) == 0);
    junk = ($urandom_range(0, 7) == 0);
    hold = 1'b0;
    set_w = 1'b1;
    set_h = 1'b1;
    n = 0;
    lvl = pix_t'($urandom_range(0, 255));
    case (ph)
      0: begin
        wv = 16'd5; hv = 16'd4; n = 60; quiet = 1'b1; hold = 1'b1;
      end
      1: begin
        wv = 16'd7; hv = 16'd5; n = 70; pause = 1'b1;
      end
      2: begin
        wv = '1; hv = 16'd3; n = 2 * WIDTH_MAX + 5;
      end
      3: begin
        wv = 16'd0; hv = 16'd4; n = 12;
      end
      4: begin
        wv = 16'd6; hv = 16'd0; n = 18;
      end
      5: begin
        wv = 16'd2; hv = 16'd6; n = 15;
      end
      6: begin
        wv = 16'd8; hv = 16'd2; n = 19;
      end
      7: begin
        wv = 16'd3; hv = '1; n = 60; junk = 1'b1;
      end
      8: begin
        wv = 16'd1; hv = 16'd5; n = 10;
      end
      9: begin
        wv = 16'd3; hv = 16'd1; n = 7;
      end
      default: begin
        pick = $urandom_range(0, 9);
        wv = (pick == 0) ? CFG_BITS'($urandom_range(1, 2))
                         : CFG_BITS'($urandom_range(3, 12));
        if (pick == 1) wv = wv | 16'hF800;
        hv = ($urandom_range(0, 7) == 0) ? CFG_BITS'($urandom_range(1, 2))
                                         : CFG_BITS'($urandom_range(3, 9));
        if (ph > 10) begin
          pick = $urandom_range(0, 9);
          if (pick < 2) set_w = 1'b0;
          else if (pick < 4) set_h = 1'b0;
        end
      end
    endcase
    wait_results(SETTLE_CYCLES);
    if (set_w) write_reg(CFG_IDX_WIDTH, wv);
    if (junk) begin
      write_reg(($urandom_range(0, 1) != 0) ? CFG_IDX_SPARE2 : CFG_IDX_SPARE3,
                CFG_BITS'($urandom));
    end
    if (set_h) write_reg(CFG_IDX_HEIGHT, hv);
    if (n == 0) begin
      frame_px = ((img_width == '0) ? 1 : img_width) * ((img_height == '0) ? 1 : img_height);
      n = frame_px * $urandom_range(1, 3);
      if ($urandom_range(0, 2) == 0) n += $urandom_range(1, frame_px);
    end
    for (int unsigned k = 0; k < n; k++) begin
      if (pause && k == n / 2) wait_results(SETTLE_CYCLES);
      if (hold && k == 8) hold_asked++;
      px = pick_pixel(lvl);
      offer_pixel(px);
      if (step_window(px, rec)) expected_codes.push_back(rec);
      plain_items++;
      if (!quiet) pause_sender(idle_len());
    end
  endtask

  initial begin : receiver
    int unsigned left;
    bit st;
    left = 0;
    st = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        st = 1'b1;
        left = HOLD_CYCLES;
      end else if (left == 0) begin
        left = idle_len();
        st = (left != 0);
        if (!st) left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 6);
      end
      out_stall <= st;
      left--;
    end
  end

  always @(posedge clk) begin : result_check
    code_rec_t want;
    code_rec_t seen;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen = {out_pattern_code, out_row_end, out_frame_end};
      if (expected_codes.size() == 0) begin
        report_miss("Unexpected request", '0, seen);
      end else begin
        want = expected_codes.pop_front();
        if (want.code !== seen.code || want.row_end !== seen.row_end ||
            want.frame_end !== seen.frame_end) begin
          report_miss("Mismatch", want, seen);
        end
      end
    end
  end

  initial begin : limit
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    code_rec_t rec;
    bit hit;
    int unsigned ph;
    img_width = WCFG_BITS'(WIDTH_MAX);
    img_height = ROW_BITS'(1024);
    for (int i = 0; i < WIDTH_MAX; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int i = 0; i < WIN_TAPS; i++) win[i] = '0;
    next_col = 0;
    next_row = 0;

    // After reset the frame is 1024 wide, so the first pixels give nothing.
    add_px(8'h00, 1'b1, 1'b0, '0);
    add_px(8'hFF, 1'b1, 1'b0, '0);
    add_wr(CFG_IDX_WIDTH, 16'd3);
    add_wr(CFG_IDX_HEIGHT, 16'd3);
    // A flat frame sets every neighbor bit; the next frame starts on wrap.
    for (int i = 0; i < 8; i++) add_px(8'h00, 1'b1, 1'b0, '0);
    add_px(8'h00, 1'b1, 1'b1, code_rec_t'({8'hFF, 1'b1, 1'b1}));
    // A bright center clears every bit, and a write to a spare index
    // in the middle of the frame must not restart it.
    for (int i = 0; i < 4; i++) add_px(8'h00, 1'b1, 1'b0, '0);
    add_px(8'hFF, 1'b1, 1'b0, '0);
    add_wr(CFG_IDX_SPARE2, 16'hFFFF);
    for (int i = 0; i < 3; i++) add_px(8'h00, 1'b1, 1'b0, '0);
    add_px(8'h00, 1'b1, 1'b1, code_rec_t'({8'h00, 1'b1, 1'b1}));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_results(SETTLE_CYCLES);
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer_pixel(plan[i].px);
        hit = step_window(plan[i].px, rec);
        if (plan[i].typed) begin
          if (plan[i].has_res) expected_codes.push_back(plan[i].rec);
        end else if (hit) begin
          expected_codes.push_back(rec);
        end
        pause_sender(idle_len());
      end
    end

    ph = 0;
    while (ph < 11 || plain_items < RANDOM_ITEMS) begin
      run_phase(ph);
      ph++;
    end

    wait_results(SETTLE_CYCLES);
    if (expected_codes.size() != 0) report_miss("Missing request", expected_codes[0], '0);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: rotation_invariant_lbp_3x3_unit.f
design/rilbp_pkg.sv
design/rilbp_line_buf.sv
design/rilbp_window.sv
design/rotation_invariant_lbp_3x3_unit.sv
tb/rotation_invariant_lbp_3x3_unit_tb.sv
